/* hw/rtl/ecns_pkg.sv */
// Shared types, constants and the quarter-wave sine table of the chirp and noise synthesizer.
package ecns_pkg;

    // Field and register widths.
    localparam int unsigned LENGTH_BITS      = 20;
    localparam int unsigned SINE_TABLE_DEPTH = 1024;
    localparam int unsigned SINE_ABITS       = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned SAMPLE_W         = 16;
    localparam int unsigned START_STEP_W     = 47;
    localparam int unsigned STEP_W           = 48;
    localparam int unsigned PHASE_W          = 32;
    localparam int unsigned FADE_W           = 16;
    localparam int unsigned GAIN_W           = 17;
    localparam int unsigned AMP_W            = 15;
    localparam int unsigned SEED_W           = 32;
    localparam int unsigned LFSR_W           = 32;
    localparam int unsigned SINE_W           = 15;
    localparam int unsigned APB_DATA_W       = 64;
    localparam int unsigned APB_ADDR_W       = 6;

    // Digit-serial schedule: 4-bit digits for the step and phase adders,
    // one multiplier bit per cycle for the shift-add multipliers.
    localparam int unsigned DIGIT_W          = 4;
    localparam int unsigned STEP_DIGITS      = STEP_W / DIGIT_W;
    localparam int unsigned PHASE_SHIFT      = 16;
    localparam int unsigned PHASE_DIGIT_LO   = PHASE_SHIFT / DIGIT_W;
    localparam int unsigned PHASE_DIGIT_HI   = PHASE_DIGIT_LO + PHASE_W / DIGIT_W;
    localparam int unsigned MUL_STEPS        = GAIN_W;
    localparam int unsigned CNT_W            = $clog2(MUL_STEPS);

    localparam logic [LFSR_W-1:0] LFSR_TAPS  = 32'h8020_0003;
    localparam logic [GAIN_W-1:0] ENV_ONE    = 17'h1_0000;
    localparam logic [AMP_W-1:0]  SAMPLE_MAX = 15'h7FFF;

    // Register map, one 64-bit word per register.
    typedef enum logic [2:0] {
        REG_WAVEFORM_MODE  = 3'd0,
        REG_START_STEP     = 3'd1,
        REG_SWEEP_STEP     = 3'd2,
        REG_LENGTH_SAMPLES = 3'd3,
        REG_FADE_SAMPLES   = 3'd4,
        REG_FADE_GAIN      = 3'd5,
        REG_AMPLITUDE      = 3'd6,
        REG_NOISE_SEED     = 3'd7
    } reg_index_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_LOAD,
        ST_MUL1,
        ST_ENV,
        ST_MUL2,
        ST_DONE
    } state_t;

    // Envelope class of the current sample.
    typedef enum logic [1:0] {
        ENV_FULL,
        ENV_RAMP,
        ENV_ZERO
    } env_sel_t;

    typedef logic [SINE_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];

    // Quarter-wave table: 32767*sin at the middle of each bin, from a Q30
    // Horner Taylor series up to x^9, rounded to Q15 and capped.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t          rom;
        longint unsigned    x;
        longint unsigned    x2;
        longint unsigned    t;
        longint unsigned    v;
        longint unsigned    pi_q30;
        longint unsigned    one_q30;
        pi_q30  = 64'd3373259426;
        one_q30 = 64'd1 << 30;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            // The bin count is a power of two, so the scaling is a shift.
            x  = (pi_q30 * (64'd2 * longint'(k) + 64'd1)) >> (SINE_ABITS + 2);
            x2 = (x * x) >> 30;
            t  = one_q30 - x2 / 64'd72;
            t  = one_q30 - ((x2 * t) >> 30) / 64'd42;
            t  = one_q30 - ((x2 * t) >> 30) / 64'd20;
            t  = one_q30 - ((x2 * t) >> 30) / 64'd6;
            v  = (x * t) >> 30;
            v  = (v * 64'd32767 + (64'd1 << 29)) >> 30;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            rom[k] = v[SINE_W-1:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

/* hw/rtl/enveloped_chirp_noise_synth_unit.sv */
// Top level of the enveloped chirp and noise synthesizer with its register port.
//
// Each accepted input beat yields exactly one result beat: one signed 16-bit
// sample, a last flag on the final sample of the sound and an active flag
// while a sound plays (an idle beat returns sample zero, last and active low).
// start_sound high restarts the sound at sample zero; start_step and
// noise_seed are taken only then, all other registers act at once. The block
// works on one beat at a time: a playing beat passes through the prepare and
// load states, two passes of bit-serial shift-add multipliers (wave times
// amplitude together with the fade ramp, then the product times the envelope)
// and the done state; an idle beat goes from prepare to done. The 48-bit step
// and 32-bit phase updates run as 4-bit digit-serial adders inside the first
// pass. A finished result waits in an output register, and the next input beat
// is taken while it waits. Registers sit on an APB port at byte address
// 8*index, 64 bits wide, and should be written only while the block is idle.
module enveloped_chirp_noise_synth_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // Register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ecns_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ecns_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ecns_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // Input channel
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                start_sound,
    // Result channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [ecns_pkg::SAMPLE_W-1:0] sample,
    output logic                                last,
    output logic                                active
);

    localparam int unsigned LB  = ecns_pkg::LENGTH_BITS;
    localparam int unsigned SW  = ecns_pkg::STEP_W;
    localparam int unsigned PW  = ecns_pkg::PHASE_W;
    localparam int unsigned DW  = ecns_pkg::DIGIT_W;
    localparam int unsigned GW  = ecns_pkg::GAIN_W;
    localparam int unsigned AW  = ecns_pkg::AMP_W;
    localparam int unsigned MW  = ecns_pkg::SAMPLE_W;
    localparam int unsigned CW  = ecns_pkg::CNT_W;
    localparam int unsigned AB  = ecns_pkg::SINE_ABITS;
    localparam int unsigned PAW = MW + AW + 1;
    localparam int unsigned PBW = LB + GW;
    localparam int unsigned PCW = PAW + GW;
    localparam int unsigned MUL_LAST = ecns_pkg::MUL_STEPS - 1;
    localparam int unsigned APB_ADDR_HI = ecns_pkg::APB_ADDR_W - 1;
    localparam int unsigned APB_ADDR_LO = 3;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic                               waveform_mode_reg,  waveform_mode_next;
    logic [ecns_pkg::START_STEP_W-1:0]  start_step_reg,     start_step_next;
    logic [SW-1:0]                      sweep_step_reg,     sweep_step_next;
    logic [LB-1:0]                      length_samples_reg, length_samples_next;
    logic [ecns_pkg::FADE_W-1:0]        fade_samples_reg,   fade_samples_next;
    logic [GW-1:0]                      fade_gain_reg,      fade_gain_next;
    logic [AW-1:0]                      amplitude_reg,      amplitude_next;
    logic [ecns_pkg::SEED_W-1:0]        noise_seed_reg,     noise_seed_next;

    ecns_pkg::state_t                   state_reg,          state_next;
    logic [CW-1:0]                      cnt_reg,            cnt_next;
    logic [LB-1:0]                      sample_index_reg,   sample_index_next;
    logic [PW-1:0]                      phase_reg,          phase_next;
    logic [SW-1:0]                      phase_step_reg,     phase_step_next;
    logic [ecns_pkg::LFSR_W-1:0]        lfsr_reg,           lfsr_next;
    logic                               playing_reg,        playing_next;
    logic                               step_carry_reg,     step_carry_next;
    logic                               phase_carry_reg,    phase_carry_next;
    logic                               result_valid_reg,   result_valid_next;

    // Payload registers, no reset.
    logic [SW-1:0]                      sweep_sh_reg,       sweep_sh_next;
    logic [ecns_pkg::SINE_W-1:0]        rom_q_reg,          rom_q_next;
    logic                               quad_neg_reg,       quad_neg_next;
    ecns_pkg::env_sel_t                 env_sel_reg,        env_sel_next;
    logic                               last_flag_reg,      last_flag_next;
    logic                               neg_reg,            neg_next;
    logic [MW-1:0]                      mcand_a_reg,        mcand_a_next;
    logic [MW-1:0]                      acc_a_reg,          acc_a_next;
    logic [GW-1:0]                      lo_a_reg,           lo_a_next;
    logic [GW-1:0]                      mpl_a_reg,          mpl_a_next;
    logic [LB-1:0]                      mcand_b_reg,        mcand_b_next;
    logic [LB-1:0]                      acc_b_reg,          acc_b_next;
    logic [GW-1:0]                      lo_b_reg,           lo_b_next;
    logic [GW-1:0]                      mpl_b_reg,          mpl_b_next;
    logic [PAW-1:0]                     mcand_c_reg,        mcand_c_next;
    logic [PAW-1:0]                     acc_c_reg,          acc_c_next;
    logic [GW-1:0]                      lo_c_reg,           lo_c_next;
    logic [GW-1:0]                      mpl_c_reg,          mpl_c_next;
    logic signed [MW-1:0]               sample_reg,         sample_next;
    logic                               last_reg,           last_next;
    logic                               active_reg,         active_next;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic                               cfg_write;
    ecns_pkg::reg_index_t               cfg_index;
    logic                               accept;
    logic [LB-1:0]                      len_eff;
    logic [LB-1:0]                      fade_ext;
    logic                               in_fade;
    logic                               out_fade;
    logic                               before_end;
    logic [AB-1:0]                      rom_index;
    logic [MW-1:0]                      noise_lo;
    logic [MW:0]                        sum_a;
    logic [LB:0]                        sum_b;
    logic [PAW:0]                       sum_c;
    logic [DW:0]                        step_digit;
    logic [DW:0]                        phase_digit;
    logic [PAW-1:0]                     prod_a;
    logic [PBW-1:0]                     prod_b;
    logic [PCW-1:0]                     prod_c;
    logic [GW-1:0]                      env_value;
    logic [GW-1:0]                      p_full;
    logic [AW-1:0]                      p_cap;
    logic [MW-1:0]                      p_mag;

    assign cfg_write  = psel && penable && pwrite && pready;
    assign cfg_index  = ecns_pkg::reg_index_t'(paddr[APB_ADDR_HI:APB_ADDR_LO]);
    assign accept     = item_valid && !item_stall;
    assign pready     = 1'b1;
    assign item_stall = (state_reg != ecns_pkg::ST_IDLE);

    // Register read back.
    always_comb
    begin
        case (cfg_index)
            ecns_pkg::REG_WAVEFORM_MODE:  prdata = 64'(waveform_mode_reg);
            ecns_pkg::REG_START_STEP:     prdata = 64'(start_step_reg);
            ecns_pkg::REG_SWEEP_STEP:     prdata = 64'(sweep_step_reg);
            ecns_pkg::REG_LENGTH_SAMPLES: prdata = 64'(length_samples_reg);
            ecns_pkg::REG_FADE_SAMPLES:   prdata = 64'(fade_samples_reg);
            ecns_pkg::REG_FADE_GAIN:      prdata = 64'(fade_gain_reg);
            ecns_pkg::REG_AMPLITUDE:      prdata = 64'(amplitude_reg);
            ecns_pkg::REG_NOISE_SEED:     prdata = 64'(noise_seed_reg);
            default:                      prdata = '0;
        endcase
    end

    // Envelope classification of the current sample index.
    assign len_eff    = (length_samples_reg == '0) ? LB'(1) : length_samples_reg;
    assign fade_ext   = LB'(fade_samples_reg);
    assign in_fade    = sample_index_reg < fade_ext;
    assign out_fade   = ({1'b0, sample_index_reg} + {1'b0, fade_ext}) > {1'b0, len_eff};
    assign before_end = sample_index_reg < len_eff;

    // Quarter-wave table address, mirrored in odd quadrants.
    assign rom_index = phase_reg[PW-2] ? ~phase_reg[PW-3 -: AB] : phase_reg[PW-3 -: AB];

    assign noise_lo = lfsr_reg[MW-1:0];

    // One step of each shift-add multiplier and of the digit adders.
    assign sum_a       = {1'b0, acc_a_reg} + {1'b0, (mpl_a_reg[0] ? mcand_a_reg : '0)};
    assign sum_b       = {1'b0, acc_b_reg} + {1'b0, (mpl_b_reg[0] ? mcand_b_reg : '0)};
    assign sum_c       = {1'b0, acc_c_reg} + {1'b0, (mpl_c_reg[0] ? mcand_c_reg : '0)};
    assign step_digit  = {1'b0, phase_step_reg[DW-1:0]} + {1'b0, sweep_sh_reg[DW-1:0]}
                         + (DW+1)'(step_carry_reg);
    assign phase_digit = {1'b0, phase_reg[DW-1:0]} + {1'b0, phase_step_reg[DW-1:0]}
                         + (DW+1)'(phase_carry_reg);

    // Finished products.
    assign prod_a = PAW'({acc_a_reg, lo_a_reg});
    assign prod_b = {acc_b_reg, lo_b_reg};
    assign prod_c = {acc_c_reg, lo_c_reg};

    // Envelope value for the second pass.
    always_comb
    begin
        case (env_sel_reg)
            ecns_pkg::ENV_FULL: env_value = ecns_pkg::ENV_ONE;
            ecns_pkg::ENV_RAMP: env_value = (prod_b > PBW'(ecns_pkg::ENV_ONE))
                                            ? ecns_pkg::ENV_ONE : prod_b[GW-1:0];
            default:            env_value = '0;
        endcase
    end

    // Scaled magnitude, capped to full scale.
    assign p_full = prod_c[PCW-2 -: GW];
    assign p_cap  = (p_full > GW'(ecns_pkg::SAMPLE_MAX)) ? ecns_pkg::SAMPLE_MAX
                                                         : p_full[AW-1:0];
    assign p_mag  = {1'b0, p_cap};

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        waveform_mode_next  = waveform_mode_reg;
        start_step_next     = start_step_reg;
        sweep_step_next     = sweep_step_reg;
        length_samples_next = length_samples_reg;
        fade_samples_next   = fade_samples_reg;
        fade_gain_next      = fade_gain_reg;
        amplitude_next      = amplitude_reg;
        noise_seed_next     = noise_seed_reg;

        state_next          = state_reg;
        cnt_next            = cnt_reg;
        sample_index_next   = sample_index_reg;
        phase_next          = phase_reg;
        phase_step_next     = phase_step_reg;
        lfsr_next           = lfsr_reg;
        playing_next        = playing_reg;
        step_carry_next     = step_carry_reg;
        phase_carry_next    = phase_carry_reg;
        result_valid_next   = result_valid_reg;

        sweep_sh_next       = sweep_sh_reg;
        rom_q_next          = rom_q_reg;
        quad_neg_next       = quad_neg_reg;
        env_sel_next        = env_sel_reg;
        last_flag_next      = last_flag_reg;
        neg_next            = neg_reg;
        mcand_a_next        = mcand_a_reg;
        acc_a_next          = acc_a_reg;
        lo_a_next           = lo_a_reg;
        mpl_a_next          = mpl_a_reg;
        mcand_b_next        = mcand_b_reg;
        acc_b_next          = acc_b_reg;
        lo_b_next           = lo_b_reg;
        mpl_b_next          = mpl_b_reg;
        mcand_c_next        = mcand_c_reg;
        acc_c_next          = acc_c_reg;
        lo_c_next           = lo_c_reg;
        mpl_c_next          = mpl_c_reg;
        sample_next         = sample_reg;
        last_next           = last_reg;
        active_next         = active_reg;

        // Register writes.
        if (cfg_write) begin
            case (cfg_index)
                ecns_pkg::REG_WAVEFORM_MODE:  waveform_mode_next  = pwdata[0];
                ecns_pkg::REG_START_STEP:     start_step_next     =
                                                  pwdata[ecns_pkg::START_STEP_W-1:0];
                ecns_pkg::REG_SWEEP_STEP:     sweep_step_next     = pwdata[SW-1:0];
                ecns_pkg::REG_LENGTH_SAMPLES: length_samples_next = pwdata[LB-1:0];
                ecns_pkg::REG_FADE_SAMPLES:   fade_samples_next   =
                                                  pwdata[ecns_pkg::FADE_W-1:0];
                ecns_pkg::REG_FADE_GAIN:      fade_gain_next      = pwdata[GW-1:0];
                ecns_pkg::REG_AMPLITUDE:      amplitude_next      = pwdata[AW-1:0];
                ecns_pkg::REG_NOISE_SEED:     noise_seed_next     =
                                                  pwdata[ecns_pkg::SEED_W-1:0];
                default:                      ;
            endcase
        end

        // The output register empties when its beat is taken.
        if (result_valid_reg && !result_stall) begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            // Take a beat; a restart loads the sound's initial state.
            ecns_pkg::ST_IDLE:
            begin
                if (accept) begin
                    if (start_sound) begin
                        sample_index_next = '0;
                        phase_next        = '0;
                        phase_step_next   = SW'(start_step_reg);
                        lfsr_next         = (noise_seed_reg == '0) ? ecns_pkg::LFSR_W'(1)
                                                                   : noise_seed_reg;
                        playing_next      = 1'b1;
                    end
                    state_next = ecns_pkg::ST_PREP;
                end
            end

            // Read the sine table, classify the envelope, load the ramp multiplier.
            ecns_pkg::ST_PREP:
            begin
                rom_q_next     = ecns_pkg::SINE_ROM[rom_index];
                quad_neg_next  = phase_reg[PW-1];
                last_flag_next = ({1'b0, sample_index_reg} + (LB+1)'(1)) >= {1'b0, len_eff};
                acc_b_next     = '0;
                mpl_b_next     = fade_gain_reg;
                if (out_fade) begin
                    env_sel_next = before_end ? ecns_pkg::ENV_RAMP : ecns_pkg::ENV_ZERO;
                    mcand_b_next = len_eff - sample_index_reg;
                end else if (in_fade) begin
                    env_sel_next = ecns_pkg::ENV_RAMP;
                    mcand_b_next = sample_index_reg;
                end else begin
                    env_sel_next = ecns_pkg::ENV_FULL;
                    mcand_b_next = sample_index_reg;
                end
                state_next = playing_reg ? ecns_pkg::ST_LOAD : ecns_pkg::ST_DONE;
            end

            // Form the wave magnitude and start the first pass.
            ecns_pkg::ST_LOAD:
            begin
                if (waveform_mode_reg) begin
                    neg_next     = noise_lo[MW-1];
                    mcand_a_next = noise_lo[MW-1] ? (~noise_lo + MW'(1)) : noise_lo;
                end else begin
                    neg_next     = quad_neg_reg;
                    mcand_a_next = MW'(rom_q_reg);
                end
                acc_a_next       = '0;
                mpl_a_next       = GW'(amplitude_reg);
                sweep_sh_next    = sweep_step_reg;
                step_carry_next  = 1'b0;
                phase_carry_next = 1'b0;
                cnt_next         = '0;
                state_next       = ecns_pkg::ST_MUL1;
            end

            // Wave times amplitude and the fade ramp; step and phase advance digit-serially.
            ecns_pkg::ST_MUL1:
            begin
                acc_a_next = sum_a[MW:1];
                lo_a_next  = {sum_a[0], lo_a_reg[GW-1:1]};
                mpl_a_next = mpl_a_reg >> 1;
                acc_b_next = sum_b[LB:1];
                lo_b_next  = {sum_b[0], lo_b_reg[GW-1:1]};
                mpl_b_next = mpl_b_reg >> 1;

                if (cnt_reg >= CW'(ecns_pkg::PHASE_DIGIT_LO) &&
                    cnt_reg <  CW'(ecns_pkg::PHASE_DIGIT_HI)) begin
                    phase_next       = {phase_digit[DW-1:0], phase_reg[PW-1:DW]};
                    phase_carry_next = phase_digit[DW];
                end
                if (cnt_reg < CW'(ecns_pkg::STEP_DIGITS)) begin
                    phase_step_next = {step_digit[DW-1:0], phase_step_reg[SW-1:DW]};
                    step_carry_next = step_digit[DW];
                    sweep_sh_next   = sweep_sh_reg >> DW;
                end

                if (cnt_reg == CW'(MUL_LAST)) begin
                    state_next = ecns_pkg::ST_ENV;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            // Cap the ramp and start the second pass.
            ecns_pkg::ST_ENV:
            begin
                mcand_c_next = prod_a;
                acc_c_next   = '0;
                mpl_c_next   = env_value;
                cnt_next     = '0;
                state_next   = ecns_pkg::ST_MUL2;
            end

            // Product times envelope.
            ecns_pkg::ST_MUL2:
            begin
                acc_c_next = sum_c[PAW:1];
                lo_c_next  = {sum_c[0], lo_c_reg[GW-1:1]};
                mpl_c_next = mpl_c_reg >> 1;
                if (cnt_reg == CW'(MUL_LAST)) begin
                    state_next = ecns_pkg::ST_DONE;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            // Hand the result to the output register and finish the state update.
            ecns_pkg::ST_DONE:
            begin
                if (!result_valid_reg || !result_stall) begin
                    result_valid_next = 1'b1;
                    if (playing_reg) begin
                        sample_next = neg_reg ? $signed(-p_mag) : $signed(p_mag);
                        last_next   = last_flag_reg;
                        active_next = 1'b1;
                        lfsr_next   = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ ecns_pkg::LFSR_TAPS)
                                                  : (lfsr_reg >> 1);
                        if (last_flag_reg) begin
                            playing_next = 1'b0;
                        end else begin
                            sample_index_next = sample_index_reg + LB'(1);
                        end
                    end else begin
                        sample_next = '0;
                        last_next   = 1'b0;
                        active_next = 1'b0;
                    end
                    state_next = ecns_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ecns_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control and architectural state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            waveform_mode_reg  <= 1'b0;
            start_step_reg     <= '0;
            sweep_step_reg     <= '0;
            length_samples_reg <= LB'(1);
            fade_samples_reg   <= ecns_pkg::FADE_W'(220);
            fade_gain_reg      <= GW'(297);
            amplitude_reg      <= '0;
            noise_seed_reg     <= ecns_pkg::SEED_W'(1);
            state_reg          <= ecns_pkg::ST_IDLE;
            cnt_reg            <= '0;
            sample_index_reg   <= '0;
            phase_reg          <= '0;
            phase_step_reg     <= '0;
            lfsr_reg           <= ecns_pkg::LFSR_W'(1);
            playing_reg        <= 1'b0;
            step_carry_reg     <= 1'b0;
            phase_carry_reg    <= 1'b0;
            result_valid_reg   <= 1'b0;
        end else begin
            waveform_mode_reg  <= waveform_mode_next;
            start_step_reg     <= start_step_next;
            sweep_step_reg     <= sweep_step_next;
            length_samples_reg <= length_samples_next;
            fade_samples_reg   <= fade_samples_next;
            fade_gain_reg      <= fade_gain_next;
            amplitude_reg      <= amplitude_next;
            noise_seed_reg     <= noise_seed_next;
            state_reg          <= state_next;
            cnt_reg            <= cnt_next;
            sample_index_reg   <= sample_index_next;
            phase_reg          <= phase_next;
            phase_step_reg     <= phase_step_next;
            lfsr_reg           <= lfsr_next;
            playing_reg        <= playing_next;
            step_carry_reg     <= step_carry_next;
            phase_carry_reg    <= phase_carry_next;
            result_valid_reg   <= result_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Datapath payload
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        sweep_sh_reg   <= sweep_sh_next;
        rom_q_reg      <= rom_q_next;
        quad_neg_reg   <= quad_neg_next;
        env_sel_reg    <= env_sel_next;
        last_flag_reg  <= last_flag_next;
        neg_reg        <= neg_next;
        mcand_a_reg    <= mcand_a_next;
        acc_a_reg      <= acc_a_next;
        lo_a_reg       <= lo_a_next;
        mpl_a_reg      <= mpl_a_next;
        mcand_b_reg    <= mcand_b_next;
        acc_b_reg      <= acc_b_next;
        lo_b_reg       <= lo_b_next;
        mpl_b_reg      <= mpl_b_next;
        mcand_c_reg    <= mcand_c_next;
        acc_c_reg      <= acc_c_next;
        lo_c_reg       <= lo_c_next;
        mpl_c_reg      <= mpl_c_next;
        sample_reg     <= sample_next;
        last_reg       <= last_next;
        active_reg     <= active_next;
    end

    assign result_valid = result_valid_reg;
    assign sample       = sample_reg;
    assign last         = last_reg;
    assign active       = active_reg;

endmodule
